### hdl/pmia_pkg.sv
// shared types, constants and tables for the polygon maximum angle block
`default_nettype none
package pmia_pkg;

	localparam int COORD_W = 32;
	localparam int ANGLE_W = 25;
	localparam int STATUS_W = 2;
	localparam int ANGLE_FRAC_BITS_DEF = 16;
	localparam int ACOS_ITERATIONS_DEF = 20;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FEW = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;

	localparam logic [ANGLE_W-1:0] ANGLE_SAT = 25'h1FFFFFF;

	// pi and pi/2 in Q30
	localparam logic [33:0] PI_Q30 = 34'd3373259426;
	localparam logic [33:0] HALF_PI_Q30 = 34'd1686629713;

	// truncated arctangent of 2^-i in Q30
	localparam logic [29:0] ATAN_TAB [32] = '{
		30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76, 30'h01FFD55B,
		30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
		30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF, 30'h00003FFF, 30'h00001FFF,
		30'h00000FFF, 30'h000007FF, 30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F,
		30'h0000003F, 30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002,
		30'h00000001, 30'h00000000
	};

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} vtx_t;

	typedef struct packed {
		logic done;
		logic ok;
		logic [ANGLE_W-1:0] angle;
	} ang_rsp_t;

endpackage
`default_nettype wire

### hdl/pmia_ifs.sv
// vertex and result channel interfaces
`default_nettype none
interface pmia_vtx_if;
	import pmia_pkg::*;
	logic valid;
	logic ready;
	logic signed [COORD_W-1:0] vertex_x;
	logic signed [COORD_W-1:0] vertex_y;
	logic signed [COORD_W-1:0] vertex_z;
	logic last_vertex;
	modport source (output valid, vertex_x, vertex_y, vertex_z, last_vertex, input ready);
	modport sink (input valid, vertex_x, vertex_y, vertex_z, last_vertex, output ready);
endinterface

interface pmia_res_if;
	import pmia_pkg::*;
	logic valid;
	logic ready;
	logic [ANGLE_W-1:0] max_angle;
	logic [STATUS_W-1:0] status;
	modport source (output valid, max_angle, status, input ready);
	modport sink (input valid, max_angle, status, output ready);
endinterface
`default_nettype wire

### hdl/pmia_sqrt.sv
// iterative floor square root of a 64-bit value, two radicand bits a cycle
`default_nettype none
module pmia_sqrt (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [63:0] radicand,
	output logic done,
	output logic [31:0] root
);
	logic [63:0] n_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic busy_q;
	logic done_q;
	logic [63:0] trial;
	logic take;

	// trial subtraction for the current bit pair
	assign trial = res_q + bit_q;
	assign take = (n_q >= trial);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= radicand;
			res_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (take) begin
				n_q <= n_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[31:0];
endmodule
`default_nettype wire

### hdl/pmia_angle.sv
// angle at one vertex: normalize, dot and lengths, divide, arc cosine by rotation
`default_nettype none
module pmia_angle #(
	parameter int ANGLE_FRAC_BITS = pmia_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int ACOS_ITERATIONS = pmia_pkg::ACOS_ITERATIONS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire pmia_pkg::vtx_t a,
	input wire pmia_pkg::vtx_t m,
	input wire pmia_pkg::vtx_t b,
	output pmia_pkg::ang_rsp_t rsp
);
	import pmia_pkg::*;

	localparam int ROT_N = (ACOS_ITERATIONS < 32) ? ACOS_ITERATIONS : 32;
	localparam int RND_SH = 30 - ANGLE_FRAC_BITS;

	typedef enum logic [14:0] {
		A_IDLE = 15'h0001,
		A_NORM = 15'h0002,
		A_MUL  = 15'h0004,
		A_SQU  = 15'h0008,
		A_WSU  = 15'h0010,
		A_SQV  = 15'h0020,
		A_WSV  = 15'h0040,
		A_DEN  = 15'h0080,
		A_DIVI = 15'h0100,
		A_DIV  = 15'h0200,
		A_QSQ  = 15'h0400,
		A_SIN  = 15'h0800,
		A_WSIN = 15'h1000,
		A_ROT  = 15'h2000,
		A_FIN  = 15'h4000
	} ast_t;

	ast_t state_q;
	logic [5:0] cnt_q;
	logic [31:0] um_q [3];
	logic [31:0] vm_q [3];
	logic [2:0] us_q;
	logic [2:0] vs_q;
	logic signed [63:0] dot_q;
	logic [63:0] su_q;
	logic [63:0] sv_q;
	logic [30:0] lu_q;
	logic [30:0] lv_q;
	logic [61:0] p_q;
	logic pv_q;
	logic [1:0] pg_q;
	logic pn_q;
	logic [62:0] r_q;
	logic [61:0] den_q;
	logic [30:0] q_q;
	logic dneg_q;
	logic signed [35:0] x_q;
	logic signed [35:0] y_q;
	logic signed [33:0] z_q;
	logic done_q;
	logic ok_q;
	logic [ANGLE_W-1:0] angle_q;

	function automatic logic [31:0] mag33(input logic signed [32:0] d);
		logic signed [32:0] n;
		n = -d;
		mag33 = d[32] ? n[31:0] : d[31:0];
	endfunction

	// edge vectors from the middle vertex
	logic signed [32:0] du [3];
	logic signed [32:0] dv [3];
	always_comb begin
		du[0] = {b.x[31], b.x} - {m.x[31], m.x};
		du[1] = {b.y[31], b.y} - {m.y[31], m.y};
		du[2] = {b.z[31], b.z} - {m.z[31], m.z};
		dv[0] = {a.x[31], a.x} - {m.x[31], m.x};
		dv[1] = {a.y[31], a.y} - {m.y[31], m.y};
		dv[2] = {a.z[31], a.z} - {m.z[31], m.z};
	end

	// normalize tests on the largest component
	logic [31:0] or_u;
	logic [31:0] or_v;
	logic fit_u;
	logic fit_v;
	assign or_u = um_q[0] | um_q[1] | um_q[2];
	assign or_v = vm_q[0] | vm_q[1] | vm_q[2];
	assign fit_u = !(|or_u[31:30]) && or_u[29];
	assign fit_v = !(|or_v[31:30]) && or_v[29];

	// shared multiplier operand select
	logic [3:0] kk;
	logic [1:0] ki;
	logic [1:0] kg;
	logic [30:0] ma;
	logic [30:0] mb;
	always_comb begin
		kk = cnt_q[3:0];
		if (kk < 4'd3) begin
			kg = 2'd0;
			ki = kk[1:0];
		end else if (kk < 4'd6) begin
			kg = 2'd1;
			ki = 2'(kk - 4'd3);
		end else begin
			kg = 2'd2;
			ki = 2'(kk - 4'd6);
		end
		ma = '0;
		mb = '0;
		priority if (state_q == A_MUL) begin
			ma = (kg == 2'd2) ? vm_q[ki][30:0] : um_q[ki][30:0];
			mb = (kg == 2'd1) ? um_q[ki][30:0] : vm_q[ki][30:0];
		end else if (state_q == A_DEN) begin
			ma = lu_q;
			mb = lv_q;
		end else if (state_q == A_QSQ) begin
			ma = q_q;
			mb = q_q;
		end
	end

	// square root unit, shared by both lengths and the sine
	logic sq_start;
	logic [63:0] sq_in;
	logic sq_done;
	logic [31:0] sq_root;
	always_comb begin
		sq_start = (state_q == A_SQU) || (state_q == A_SQV) || (state_q == A_SIN);
		priority if (state_q == A_SQU) sq_in = su_q;
		else if (state_q == A_SQV) sq_in = sv_q;
		else sq_in = (64'd1 << 60) - {2'b00, p_q};
	end

	pmia_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(sq_start),
		.radicand(sq_in),
		.done(sq_done),
		.root(sq_root)
	);

	// magnitude of the dot product and divider step
	logic [63:0] dot_abs;
	logic [63:0] r2;
	logic div_ge;
	always_comb begin
		dot_abs = dot_q[63] ? 64'(-dot_q) : 64'(dot_q);
		r2 = {r_q, 1'b0};
		div_ge = (r2 >= {2'b00, den_q});
	end

	// rotation step
	logic signed [35:0] xs;
	logic signed [35:0] ys;
	logic signed [33:0] at;
	always_comb begin
		xs = x_q >>> cnt_q[4:0];
		ys = y_q >>> cnt_q[4:0];
		at = $signed({4'b0000, ATAN_TAB[cnt_q[4:0]]});
	end

	// clamp, fold and round
	logic signed [33:0] zc;
	logic [33:0] ang;
	logic [34:0] rsum;
	logic [34:0] rnd;
	always_comb begin
		if (z_q[33]) zc = '0;
		else if (z_q > $signed(HALF_PI_Q30)) zc = $signed(HALF_PI_Q30);
		else zc = z_q;
		ang = dneg_q ? (PI_Q30 - 34'(zc)) : 34'(zc);
		rsum = {1'b0, ang} + (35'd1 << (RND_SH - 1));
		rnd = rsum >> RND_SH;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
			pv_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			pv_q <= (state_q == A_MUL) && (cnt_q[3:0] < 4'd9);
			unique case (state_q)
				A_IDLE: if (start) state_q <= A_NORM;
				A_NORM: begin
					if (or_u == '0 || or_v == '0) begin
						done_q <= 1'b1;
						state_q <= A_IDLE;
					end else if (fit_u && fit_v) begin
						cnt_q <= '0;
						state_q <= A_MUL;
					end
				end
				A_MUL: begin
					if (cnt_q[3:0] == 4'd9) state_q <= A_SQU;
					else cnt_q <= cnt_q + 6'd1;
				end
				A_SQU: state_q <= A_WSU;
				A_WSU: if (sq_done) state_q <= A_SQV;
				A_SQV: state_q <= A_WSV;
				A_WSV: if (sq_done) state_q <= A_DEN;
				A_DEN: state_q <= A_DIVI;
				A_DIVI: begin
					cnt_q <= '0;
					if (dot_abs[61:0] >= p_q) state_q <= A_QSQ;
					else state_q <= A_DIV;
				end
				A_DIV: begin
					if (cnt_q == 6'd29) state_q <= A_QSQ;
					else cnt_q <= cnt_q + 6'd1;
				end
				A_QSQ: state_q <= A_SIN;
				A_SIN: state_q <= A_WSIN;
				A_WSIN: begin
					cnt_q <= '0;
					if (sq_done) state_q <= A_ROT;
				end
				A_ROT: begin
					if (cnt_q == 6'(ROT_N)) state_q <= A_FIN;
					else cnt_q <= cnt_q + 6'd1;
				end
				A_FIN: begin
					done_q <= 1'b1;
					state_q <= A_IDLE;
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		p_q <= ma * mb;
		pg_q <= kg;
		pn_q <= us_q[ki] ^ vs_q[ki];
		if (pv_q) begin
			unique case (pg_q)
				2'd0: dot_q <= pn_q ? (dot_q - $signed({2'b00, p_q}))
					: (dot_q + $signed({2'b00, p_q}));
				2'd1: su_q <= su_q + {2'b00, p_q};
				default: sv_q <= sv_q + {2'b00, p_q};
			endcase
		end
		unique case (state_q)
			A_IDLE: begin
				for (int i = 0; i < 3; i++) begin
					um_q[i] <= mag33(du[i]);
					vm_q[i] <= mag33(dv[i]);
					us_q[i] <= du[i][32];
					vs_q[i] <= dv[i][32];
				end
			end
			A_NORM: begin
				for (int i = 0; i < 3; i++) begin
					if (|or_u[31:30]) um_q[i] <= um_q[i] >> 1;
					else if (!or_u[29]) um_q[i] <= {um_q[i][30:0], 1'b0};
					if (|or_v[31:30]) vm_q[i] <= vm_q[i] >> 1;
					else if (!or_v[29]) vm_q[i] <= {vm_q[i][30:0], 1'b0};
				end
				dot_q <= '0;
				su_q <= '0;
				sv_q <= '0;
				ok_q <= 1'b0;
			end
			A_WSU: if (sq_done) lu_q <= sq_root[30:0];
			A_WSV: if (sq_done) lv_q <= sq_root[30:0];
			A_DIVI: begin
				dneg_q <= dot_q[63];
				r_q <= dot_abs[62:0];
				den_q <= p_q;
				q_q <= (dot_abs[61:0] >= p_q) ? (31'd1 << 30) : '0;
			end
			A_DIV: begin
				r_q <= div_ge ? 63'(r2 - {2'b00, den_q}) : r2[62:0];
				q_q <= {q_q[29:0], div_ge};
			end
			A_WSIN: begin
				x_q <= $signed({5'b00000, q_q});
				y_q <= $signed({4'b0000, sq_root});
				z_q <= '0;
			end
			A_ROT: begin
				if (cnt_q != 6'(ROT_N)) begin
					if (!y_q[35]) begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + at;
					end else begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - at;
					end
				end
			end
			A_FIN: begin
				ok_q <= 1'b1;
				angle_q <= (rnd > 35'(ANGLE_SAT)) ? ANGLE_SAT : rnd[ANGLE_W-1:0];
			end
			default: ;
		endcase
	end

	assign rsp = '{done: done_q, ok: ok_q, angle: angle_q};
endmodule
`default_nettype wire

### hdl/polygon_max_internal_angle.sv
// top level: vertex ring bookkeeping, running maximum and result register
//
// Vertices arrive on vtx, one per request, with last_vertex set on the final
// vertex of a polygon. One result request leaves on res for each last vertex:
// max_angle in radians (ANGLE_FRAC_BITS fraction bits) and status
// (0 ok, 1 fewer than three vertices, 2 no valid angle).
// The block works on one vertex at a time and holds vtx.ready low meanwhile.
// From the third vertex on, each vertex takes one angle evaluation; a last
// vertex takes three (its own middle neighbor, itself and the first vertex).
// One evaluation runs on the shared angle unit: up to 29 normalize shifts,
// nine dot and squared-length products, three 32-bit square roots, a divide
// of up to 30 quotient bits and ACOS_ITERATIONS rotation steps, at most 32.
// Vertices that need no angle go through S_WRAP, and S_FIN too when they
// end a polygon; S_FIN loads the result once the output register is free.
// Reset clears the vertex count and running maximum and drops res.valid.
// A result waits in its output register while res.ready is low; the next
// vertex is still taken, and a further result waits until the first leaves.
`default_nettype none
module polygon_max_internal_angle #(
	parameter int ANGLE_FRAC_BITS = pmia_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int ACOS_ITERATIONS = pmia_pkg::ACOS_ITERATIONS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	pmia_vtx_if.sink vtx,
	pmia_res_if.source res
);
	import pmia_pkg::*;

	localparam logic [63:0] DEG_FULL = 64'd360 << ANGLE_FRAC_BITS;
	localparam logic [ANGLE_W-1:0] DEG_ANGLE =
		(DEG_FULL > 64'(ANGLE_SAT)) ? ANGLE_SAT : DEG_FULL[ANGLE_W-1:0];

	localparam logic [1:0] JOB_MID = 2'd0;
	localparam logic [1:0] JOB_LAST = 2'd1;
	localparam logic [1:0] JOB_FIRST = 2'd2;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_START = 5'b00010,
		S_WAIT  = 5'b00100,
		S_WRAP  = 5'b01000,
		S_FIN   = 5'b10000
	} st_t;

	st_t state_q;
	logic [1:0] job_q;
	logic [1:0] cnt_q;
	logic last_q;
	logic any_q;
	logic [ANGLE_W-1:0] max_q;
	vtx_t cur_q;
	vtx_t p0_q;
	vtx_t p1_q;
	vtx_t f0_q;
	vtx_t f1_q;
	logic [ANGLE_W-1:0] rmax_q;
	logic [STATUS_W-1:0] rst_q;
	logic ov_q;
	logic [ANGLE_W-1:0] oang_q;
	logic [STATUS_W-1:0] ost_q;

	logic accept;
	logic ang_start;
	logic res_load;
	vtx_t op_a;
	vtx_t op_m;
	vtx_t op_b;
	ang_rsp_t ang_rsp;

	assign vtx.ready = (state_q == S_IDLE);
	assign accept = vtx.valid && vtx.ready;
	assign ang_start = (state_q == S_START);
	assign res_load = (state_q == S_FIN) && (!ov_q || res.ready);

	// operand select for the current angle
	always_comb begin
		unique case (job_q)
			JOB_LAST: begin
				op_a = p1_q;
				op_m = cur_q;
				op_b = f0_q;
			end
			JOB_FIRST: begin
				op_a = cur_q;
				op_m = f0_q;
				op_b = f1_q;
			end
			default: begin
				op_a = p0_q;
				op_m = p1_q;
				op_b = cur_q;
			end
		endcase
	end

	pmia_angle #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
		.ACOS_ITERATIONS(ACOS_ITERATIONS)
	) u_angle (
		.clk(clk),
		.arst_n(arst_n),
		.start(ang_start),
		.a(op_a),
		.m(op_m),
		.b(op_b),
		.rsp(ang_rsp)
	);

	// sequencer and running state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			job_q <= JOB_MID;
			cnt_q <= '0;
			last_q <= 1'b0;
			any_q <= 1'b0;
			max_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (res_load) ov_q <= 1'b1;
			else if (res.ready) ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_q <= vtx.last_vertex;
						job_q <= JOB_MID;
						if (cnt_q >= 2'd2) state_q <= S_START;
						else state_q <= S_WRAP;
					end
				end
				S_START: state_q <= S_WAIT;
				S_WAIT: begin
					if (ang_rsp.done) begin
						if (ang_rsp.ok) begin
							any_q <= 1'b1;
							if (!any_q || ang_rsp.angle > max_q) max_q <= ang_rsp.angle;
						end
						if (job_q == JOB_MID && last_q) begin
							job_q <= JOB_LAST;
							state_q <= S_START;
						end else if (job_q == JOB_LAST) begin
							job_q <= JOB_FIRST;
							state_q <= S_START;
						end else begin
							state_q <= S_WRAP;
						end
					end
				end
				S_WRAP: begin
					if (!last_q) begin
						if (cnt_q != 2'd3) cnt_q <= cnt_q + 2'd1;
						state_q <= S_IDLE;
					end else begin
						cnt_q <= '0;
						any_q <= 1'b0;
						max_q <= '0;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (res_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// vertex and result payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q <= '{x: vtx.vertex_x, y: vtx.vertex_y, z: vtx.vertex_z};
			if (cnt_q == 2'd0) f0_q <= '{x: vtx.vertex_x, y: vtx.vertex_y, z: vtx.vertex_z};
			if (cnt_q == 2'd1) f1_q <= '{x: vtx.vertex_x, y: vtx.vertex_y, z: vtx.vertex_z};
		end
		if (state_q == S_WRAP) begin
			p0_q <= p1_q;
			p1_q <= cur_q;
			if (cnt_q < 2'd2) begin
				rmax_q <= DEG_ANGLE;
				rst_q <= ST_FEW;
			end else if (any_q) begin
				rmax_q <= max_q;
				rst_q <= ST_OK;
			end else begin
				rmax_q <= '0;
				rst_q <= ST_NONE;
			end
		end
		if (res_load) begin
			oang_q <= rmax_q;
			ost_q <= rst_q;
		end
	end

	assign res.valid = ov_q;
	assign res.max_angle = oang_q;
	assign res.status = ost_q;

	// checks
	a_start_gap: assert property (@(posedge clk) disable iff (!arst_n)
		ang_start |=> !ang_rsp.done)
		else $error("angle unit answered right after start");
	a_rise_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> $past(state_q == S_FIN))
		else $error("result raised outside the finish step");
	a_few_value: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.status == ST_FEW) |-> (res.max_angle == DEG_ANGLE))
		else $error("degenerate polygon with wrong angle");
	a_none_value: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.status == ST_NONE) |-> (res.max_angle == '0))
		else $error("no valid angle but nonzero result");
endmodule
`default_nettype wire
